// File: rtl/linear_interp_resampler_defines.svh
// Assertion macros used by the resampler's controller.
`ifndef LINEAR_INTERP_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LIR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("linear_interp_resampler: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("linear_interp_resampler: next-cycle check failed");

`endif

// File: rtl/lir_pkg.sv
// Types and constants shared by the resampler modules.
package lir_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int STEP_BITS     = 20;
   localparam int FRAC_BITS_DEF = 16;
   localparam int MAX_OUT       = 32;
   localparam int CNT_BITS      = $clog2(MAX_OUT + 1);

   localparam logic [STEP_BITS-1:0] STEP_MIN   = STEP_BITS'(4096);
   localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(65536);

   // One input request.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] in_sample;
      logic                          in_last;
   } req_type;

   // One result.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_sample;
      logic                          run_last;
      logic                          stream_done;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul;
      logic emit;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic more;
      logic out_free;
   } sts_type;

endpackage

// File: rtl/lir_ctrl.sv
// Sequencing state machine of the resampler.
`include "linear_interp_resampler_defines.svh"

module lir_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lir_pkg::sts_type sts,
   output lir_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Requests are taken only between items.
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (sts.more) begin
               cmd.mul  = 1'b1;
               state_in = ST_EMIT;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A result is only written into a free output register.
   `LIR_ASSERT_NOW(a_emit_free, clock, reset, cmd.emit, sts.out_free)
   // An accepted request always starts the output loop.
   `LIR_ASSERT_NEXT(a_load_run, clock, reset, cmd.load, state_ff == ST_RUN)
   // A blocked result waits without losing its place.
   `LIR_ASSERT_NEXT(a_emit_hold, clock, reset,
      (state_ff == ST_EMIT) && !sts.out_free, state_ff == ST_EMIT)

endmodule

// File: rtl/lir_datapath.sv
// Datapath of the resampler: step register, stream state, interpolator, result register.
module lir_datapath #(
   parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [lir_pkg::STEP_BITS-1:0]       csr_wr_data,
   input  lir_pkg::req_type                    req_payload,
   input  lir_pkg::cmd_type                    cmd,
   output lir_pkg::sts_type                    sts,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output lir_pkg::rsp_type                    rsp_payload
);

   localparam int SB     = lir_pkg::SAMPLE_BITS;
   localparam int SW     = lir_pkg::STEP_BITS;
   localparam int CW     = lir_pkg::CNT_BITS;
   localparam int POS_W  = ((FRAC_BITS + 2 > SW + 1) ? FRAC_BITS + 2 : SW + 1) + 1;
   localparam int PROD_W = SB + FRAC_BITS + 2;
   localparam logic [POS_W-1:0] ONE_POS = {{(POS_W-1){1'b0}}, 1'b1} << FRAC_BITS;
   localparam logic [POS_W-1:0] TWO_POS = ONE_POS << 1;
   localparam logic [CW-1:0]    MAX_CNT = CW'(lir_pkg::MAX_OUT);

   logic [SW-1:0]             step_ff, step_in;
   logic signed [SB-1:0]      held_ff, held_in;
   logic                      have_ff, have_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic signed [SB-1:0]      x_ff, x_in;
   logic                      last_ff, last_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [SB-1:0]      base_ff, base_in;
   logic                      valid_ff, valid_in;
   lir_pkg::rsp_type          rsp_ff, rsp_in;

   logic [SW-1:0]             step_eff;
   logic [POS_W-1:0]          step_ext;
   logic [POS_W-1:0]          pos_sum;
   logic [POS_W-1:0]          pos_sum2;
   logic [CW-1:0]             cnt_inc;
   logic                      more_next;
   logic signed [SB-1:0]      a_sel;
   logic [FRAC_BITS-1:0]      frac_sel;
   logic signed [SB:0]        diff;
   logic signed [PROD_W-1:0]  quot;
   logic signed [SB:0]        sum;

   // Whether another result is due at position pos, given pos plus one step.
   function automatic logic more_fn(input logic [CW-1:0] cnt, input logic [POS_W-1:0] pos,
                                    input logic [POS_W-1:0] pos_step, input logic held_v,
                                    input logic last_v);
      logic ok;
      if (held_v) begin
         ok = last_v ? (pos_step <= TWO_POS) : (pos < ONE_POS);
      end else begin
         ok = last_v && (pos_step <= ONE_POS);
      end
      return (cnt < MAX_CNT) && ok;
   endfunction

   // Effective step, clamped at one sixteenth.
   assign step_eff = (step_ff < lir_pkg::STEP_MIN) ? lir_pkg::STEP_MIN : step_ff;
   assign step_ext = POS_W'(step_eff);
   assign pos_sum  = pos_ff + step_ext;
   assign pos_sum2 = pos_sum + step_ext;
   assign cnt_inc  = cnt_ff + CW'(1);

   // Loop conditions for the current and the following result.
   assign sts.more     = more_fn(cnt_ff, pos_ff, pos_sum, have_ff, last_ff);
   assign more_next    = more_fn(cnt_inc, pos_sum, pos_sum2, have_ff, last_ff);
   assign sts.out_free = !valid_ff || !rsp_stall;

   // Interpolation operands: past the held interval the new sample repeats.
   assign a_sel    = (have_ff && (pos_ff < ONE_POS)) ? held_ff : x_ff;
   assign frac_sel = (have_ff && (pos_ff < ONE_POS)) ? pos_ff[FRAC_BITS-1:0] : '0;
   assign diff     = {x_ff[SB-1], x_ff} - {a_sel[SB-1], a_sel};

   // Floor of the scaled product, then the add back onto the base sample.
   assign quot = prod_ff >>> FRAC_BITS;
   assign sum  = {base_ff[SB-1], base_ff} + quot[SB:0];

   // Next-state logic for all registers.
   always_comb begin
      step_in  = csr_wr_en ? csr_wr_data : step_ff;
      held_in  = held_ff;
      have_in  = have_ff;
      pos_in   = pos_ff;
      x_in     = x_ff;
      last_in  = last_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      base_in  = base_ff;
      valid_in = valid_ff && rsp_stall;
      rsp_in   = rsp_ff;

      if (cmd.load) begin
         x_in    = req_payload.in_sample;
         last_in = req_payload.in_last;
         cnt_in  = '0;
      end

      if (cmd.mul) begin
         prod_in = PROD_W'(diff) * PROD_W'(signed'({1'b0, frac_sel}));
         base_in = a_sel;
      end

      if (cmd.emit) begin
         rsp_in.out_sample  = sum[SB-1:0];
         rsp_in.run_last    = !more_next;
         rsp_in.stream_done = last_ff && !more_next;
         valid_in           = 1'b1;
         pos_in             = pos_sum;
         cnt_in             = cnt_inc;
      end

      if (cmd.finish) begin
         if (last_ff) begin
            held_in = '0;
            have_in = 1'b0;
            pos_in  = '0;
         end else begin
            held_in = x_ff;
            have_in = 1'b1;
            pos_in  = (pos_ff >= ONE_POS) ? (pos_ff - ONE_POS) : '0;
         end
      end
   end

   // Control and stream state.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= lir_pkg::STEP_RESET;
         held_ff  <= '0;
         have_ff  <= 1'b0;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         held_ff  <= held_in;
         have_ff  <= have_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      last_ff <= last_in;
      prod_ff <= prod_in;
      base_ff <= base_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: rtl/linear_interp_resampler.sv
// Top level of the linear-interpolation sample rate converter.
//
//   Port group   Direction  Handshake                Carries
//   req_*        in         req_valid / req_stall    input sample, last-of-stream flag
//   rsp_*        out        rsp_valid / rsp_stall    output sample, run_last, stream_done
//   csr_*        in         csr_wr_en                phase step, unsigned Q.16
//
// A request is handled in steps: accept, then per result a multiply and an add into
// the result register, and last an update of the stream state.
// The single shared multiplier and its product register set that split.
// The first sample of a stream gives no result unless it also ends the stream.
// Synchronous reset clears the stream state and sets the phase step to 65536.
// While rsp_stall holds a result, the next result waits after its multiply, and
// requests stay stalled until the stream state update after the last result.
module linear_interp_resampler #(
   parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [lir_pkg::STEP_BITS-1:0] csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lir_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lir_pkg::rsp_type              rsp_payload
);

   lir_pkg::cmd_type cmd;
   lir_pkg::sts_type sts;

   // Sequencer.
   lir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic and state.
   lir_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the linear-interpolation sample rate converter.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     SB         = lir_pkg::SAMPLE_BITS;
   localparam int     SW         = lir_pkg::STEP_BITS;
   localparam int     FRAC       = lir_pkg::FRAC_BITS_DEF;
   localparam longint UNITY      = longint'(1) << FRAC;
   // Longest run of one request (accept, a multiply and an add per result, state update), plus margin.
   localparam int     SETTLE_CYC = 2 + 2 * lir_pkg::MAX_OUT + 16;
   localparam int     CYCLE_CAP  = 1000000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [SW-1:0]        csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   lir_pkg::req_type     req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   lir_pkg::rsp_type     rsp_payload;

   // Own copy of the converter state and of the phase step register.
   logic [SW-1:0]        cur_step = lir_pkg::STEP_RESET;
   longint               held_smp = 0;
   bit                   held_ok = 1'b0;
   longint               rd_pos = 0;

   lir_pkg::rsp_type     exp_rsp_q[$];
   int                   err_count = 0;
   int                   cycle_cnt = 0;
   int                   send_idle_pct = 0;
   int                   stall_pct = 0;

   linear_interp_resampler u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // Runaway guard.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_CAP) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The receiver stalls at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Interpolate between a and b at a fraction in Q.FRAC, rounding towards minus infinity.
   function automatic logic [SB-1:0] lerp(longint a, longint b, longint frac);
      longint prod;
      prod = (b - a) * frac;
      return SB'(a + (prod >>> FRAC));
   endfunction

   // Work out the results that one accepted request causes and queue them.
   task automatic predict_req(lir_pkg::req_type r);
      longint                 step;
      longint                 x;
      longint                 a;
      logic [SB-1:0]          outs[$];
      lir_pkg::rsp_type       item;
      int                     n;
      step = (cur_step < lir_pkg::STEP_MIN) ? longint'(lir_pkg::STEP_MIN)
                                            : longint'(cur_step);
      x = longint'($signed(r.in_sample));
      n = 0;
      if (!held_ok) begin
         // The first sample of a stream is only stored, unless it also ends it.
         if (!r.in_last) begin
            held_smp = x;
            held_ok = 1'b1;
            return;
         end
         while (n < lir_pkg::MAX_OUT && rd_pos + step <= UNITY) begin
            outs.push_back(x[SB-1:0]);
            n++;
            rd_pos += step;
         end
      end else begin
         a = held_smp;
         while (n < lir_pkg::MAX_OUT && rd_pos < UNITY &&
                (!r.in_last || rd_pos + step <= 2 * UNITY)) begin
            outs.push_back(lerp(a, x, rd_pos));
            n++;
            rd_pos += step;
         end
         if (r.in_last) begin
            // Positions past the final sample repeat it.
            while (n < lir_pkg::MAX_OUT && rd_pos + step <= 2 * UNITY) begin
               outs.push_back(x[SB-1:0]);
               n++;
               rd_pos += step;
            end
         end else begin
            rd_pos = (rd_pos >= UNITY) ? rd_pos - UNITY : 0;
            held_smp = x;
         end
      end
      for (int i = 0; i < n; i++) begin
         item.out_sample  = outs[i];
         item.run_last    = (i == n - 1);
         item.stream_done = (i == n - 1) && r.in_last;
         exp_rsp_q.push_back(item);
      end
      if (r.in_last) begin
         held_smp = 0;
         held_ok = 1'b0;
         rd_pos = 0;
      end
   endtask

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin
      lir_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (exp_rsp_q.size() == 0) begin
            if (err_count < 10)
               $display("unexpected result: sample %0d run_last %0b stream_done %0b",
                        $signed(rsp_payload.out_sample), rsp_payload.run_last,
                        rsp_payload.stream_done);
            err_count++;
         end else begin
            want = exp_rsp_q.pop_front();
            if (want !== rsp_payload) begin
               if (err_count < 10)
                  $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                           $signed(want.out_sample), want.run_last, want.stream_done,
                           $signed(rsp_payload.out_sample), rsp_payload.run_last,
                           rsp_payload.stream_done);
               err_count++;
            end
         end
      end
   end

   // Offer one request, with random idle cycles ahead of it, and wait until it is taken.
   task automatic send_req(logic [SB-1:0] smp, logic last);
      lir_pkg::req_type r;
      r.in_sample = smp;
      r.in_last   = last;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      predict_req(r);
   endtask

   // Stop offering requests and let every outstanding result come out.
   task automatic drain_idle();
      req_valid <= 1'b0;
      while (exp_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // Write the phase step once the block has gone quiet.
   task automatic set_step(logic [SW-1:0] value);
      drain_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_step = value;
   endtask

   function automatic logic [SB-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return SB'($urandom_range(0, 64) - 32);
         default: return SB'($urandom);
      endcase
   endfunction

   function automatic logic [SW-1:0] rand_step();
      case ($urandom_range(0, 11))
         0:       return SW'($urandom_range(0, 4095));
         1:       return SW'($urandom_range(524289, 20'hFFFFF));
         2:       return SW'(4096);
         3:       return SW'(65536);
         4:       return SW'(524288);
         5:       return SW'($urandom_range(60000, 70000));
         default: return SW'($urandom_range(4096, 524288));
      endcase
   endfunction

   // Equal rates pass samples through one sample late; extremes of the sample range.
   task automatic test_passthrough();
      send_req(16'h7FFF, 1'b0);
      send_req(16'h8000, 1'b0);
      send_req(16'h7FFF, 1'b0);
      send_req(16'h0000, 1'b0);
      send_req(16'hFFFF, 1'b1);
   endtask

   // A stream of one sample repeats it floor(1/step) times.
   task automatic test_single_sample();
      set_step(SW'(4096));
      send_req(16'h1234, 1'b1);
      send_req(16'h8000, 1'b1);
      set_step(SW'(65536));
      send_req(16'h7FFF, 1'b1);
   endtask

   // Streams too short for any result still clear the state.
   task automatic test_short_stream();
      set_step(SW'(20'h30000));
      send_req(16'h4000, 1'b1);
      send_req(16'hC000, 1'b0);
      send_req(16'h3FFF, 1'b1);
   endtask

   // Steps below one sixteenth act as one sixteenth; this also reaches the result limit.
   task automatic test_step_clamp();
      set_step(SW'(0));
      send_req(16'h8000, 1'b0);
      send_req(16'h7FFF, 1'b0);
      send_req(16'h8000, 1'b0);
      send_req(16'h7FFF, 1'b1);
      set_step(SW'(100));
      send_req(16'h5555, 1'b1);
   endtask

   // The largest steps: full register value and the top of the intended range.
   task automatic test_extreme_step();
      set_step(SW'(20'hFFFFF));
      send_req(16'h2AAA, 1'b1);
      set_step(SW'(524288));
      for (int i = 0; i < 8; i++)
         send_req(rand_sample(), i == 7);
   endtask

   // Random streams under one idling pattern, with a new step after each group of at least 20 samples.
   task automatic test_random_phase(int idle_pct, int hold_pct, int n_items);
      int sent;
      int group;
      int len;
      send_idle_pct = idle_pct;
      stall_pct     = hold_pct;
      sent = 0;
      while (sent < n_items) begin
         set_step(rand_step());
         group = 0;
         while (group < 20 && sent < n_items) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            for (int i = 0; i < len; i++)
               send_req(rand_sample(), i == len - 1);
            group += len;
            sent  += len;
         end
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_passthrough();
      test_single_sample();
      test_short_stream();
      test_step_clamp();
      test_extreme_step();
      test_random_phase(0, 0, 105);
      test_random_phase(61, 0, 105);
      test_random_phase(0, 61, 105);
      test_random_phase(6, 6, 105);
      drain_idle();
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
